FILE: rtl/flame_flicker_color_generator_unit_defines.svh
// assertion macros for the flame flicker color generator
// used by ffcg_update and the top level, which both have i_clk and i_rst_n
`ifndef FLAME_FLICKER_COLOR_GENERATOR_UNIT_DEFINES_SVH
`define FLAME_FLICKER_COLOR_GENERATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FFCG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffcg same-cycle check failed");
`define FFCG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffcg next-cycle check failed");
`else
`define FFCG_ASSERT_NOW(lbl, ante, cons)
`define FFCG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ffcg_pkg.sv
// shared types, constants and the flame template for the flicker color generator
// no dependencies
`default_nettype none

package ffcg_pkg;

    localparam int MAX_PIXELS = 1024;
    localparam int IDX_W      = $clog2(MAX_PIXELS);
    localparam int CNT_W      = 11;
    localparam int DRAW_W     = 7;
    localparam int LEVEL_W    = 8;
    localparam int FB_W       = 8;
    localparam int SCALE_W    = 9;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;

    // shared multiplier operand widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 13;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // brightness limits in 0.005 steps
    localparam logic [FB_W-1:0]   FB_RESET    = 8'd130;
    localparam logic [FB_W:0]     FB_LOW      = 9'd130;
    localparam logic [FB_W:0]     FB_HIGH     = 9'd200;
    localparam logic [DRAW_W-1:0] DRAW_UP_FB  = 7'd10;
    localparam logic [DRAW_W-1:0] DRAW_DOWN   = 7'd10;
    localparam logic [DRAW_W-1:0] DRAW_UP_IDX = 7'd90;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 9'd90;
    localparam logic [CNT_W-1:0]   COUNT_RESET = 11'd60;

    // reciprocals: floor(x*R >> k) == floor(x/d) over the ranges used
    localparam logic [MUL_B_W-1:0] RECIP_30 = 13'd2185;   // k = 16, x < 1024
    localparam logic [MUL_B_W-1:0] RECIP_25 = 13'd5243;   // k = 17, x < 4096

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS_SCALE = 2'd0,
        REG_PIXEL_COUNT      = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [DRAW_W-1:0] draw_brightness;
        logic [DRAW_W-1:0] draw_green;
        logic [DRAW_W-1:0] draw_red;
    } t_in_req;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_out_res;

    // 30-entry flame color template
    function automatic logic [5:0] tpl_lookup(input logic [4:0] idx);
        logic [5:0] v;
        unique case (idx)
            5'd0:  v = 6'd46;  5'd1:  v = 6'd47;  5'd2:  v = 6'd49;
            5'd3:  v = 6'd51;  5'd4:  v = 6'd53;  5'd5:  v = 6'd55;
            5'd6:  v = 6'd55;  5'd7:  v = 6'd56;  5'd8:  v = 6'd57;
            5'd9:  v = 6'd58;  5'd10: v = 6'd57;  5'd11: v = 6'd56;
            5'd12: v = 6'd55;  5'd13: v = 6'd54;  5'd14: v = 6'd52;
            5'd15: v = 6'd51;  5'd16: v = 6'd50;  5'd17: v = 6'd49;
            5'd18: v = 6'd49;  5'd19: v = 6'd50;  5'd20: v = 6'd51;
            5'd21: v = 6'd53;  5'd22: v = 6'd54;  5'd23: v = 6'd55;
            5'd24: v = 6'd55;  5'd25: v = 6'd54;  5'd26: v = 6'd52;
            5'd27: v = 6'd50;  5'd28: v = 6'd48;  5'd29: v = 6'd47;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ffcg_mul.sv
// shared unsigned multiplier with registered product
// depends on ffcg_pkg
`default_nettype none

module ffcg_mul (
    input  wire logic                          i_clk,
    input  wire logic [ffcg_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic [ffcg_pkg::MUL_B_W-1:0]  i_b,
    output logic      [ffcg_pkg::MUL_P_W-1:0]  o_p
);

    logic [ffcg_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= ffcg_pkg::MUL_P_W'(i_a) * ffcg_pkg::MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: rtl/ffcg_update.sv
// per-tick state update: brightness walk and the two clamped template indices
// depends on ffcg_pkg and the assertion macro header
`default_nettype none
`include "flame_flicker_color_generator_unit_defines.svh"

module ffcg_update (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_step,
    input  wire ffcg_pkg::t_in_req                i_draws,
    input  wire logic [ffcg_pkg::CNT_W-1:0]       i_pixel_count,
    output logic      [ffcg_pkg::FB_W-1:0]        o_fb,
    output logic      [ffcg_pkg::IDX_W-1:0]       o_red_idx,
    output logic      [ffcg_pkg::IDX_W-1:0]       o_green_idx
);

    localparam int SW = ffcg_pkg::IDX_W + 2;

    logic [ffcg_pkg::FB_W-1:0]  r_fb,        n_fb;
    logic [ffcg_pkg::IDX_W-1:0] r_red_idx,   n_red_idx;
    logic [ffcg_pkg::IDX_W-1:0] r_green_idx, n_green_idx;
    logic [ffcg_pkg::FB_W:0]    w_walk;
    logic [ffcg_pkg::CNT_W:0]   w_count;
    logic [ffcg_pkg::IDX_W-1:0] w_top;

    function automatic logic [ffcg_pkg::IDX_W-1:0] move_idx(
        input logic [ffcg_pkg::IDX_W-1:0]  idx,
        input logic [ffcg_pkg::DRAW_W-1:0] draw,
        input logic [ffcg_pkg::IDX_W-1:0]  top
    );
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] t;
        logic [ffcg_pkg::IDX_W-1:0] res;
        v = $signed({2'b00, idx});
        t = $signed({2'b00, top});
        if (draw < ffcg_pkg::DRAW_DOWN) begin
            v = v - SW'(1);
        end else if (draw > ffcg_pkg::DRAW_UP_IDX) begin
            v = v + SW'(1);
        end
        if (v >= t) begin
            res = top;
        end else if (v <= 0) begin
            res = '0;
        end else begin
            res = v[ffcg_pkg::IDX_W-1:0];
        end
        return res;
    endfunction

    // effective count saturated to 1..MAX_PIXELS, top = count - 1
    always_comb begin
        w_count = {1'b0, i_pixel_count};
        if (w_count == '0) begin
            w_count = (ffcg_pkg::CNT_W+1)'(1);
        end else if (w_count > (ffcg_pkg::CNT_W+1)'(ffcg_pkg::MAX_PIXELS)) begin
            w_count = (ffcg_pkg::CNT_W+1)'(ffcg_pkg::MAX_PIXELS);
        end
        w_top = ffcg_pkg::IDX_W'(w_count - (ffcg_pkg::CNT_W+1)'(1));
    end

    always_comb begin
        w_walk = {1'b0, r_fb};
        if (i_draws.draw_brightness > ffcg_pkg::DRAW_UP_FB) begin
            w_walk = w_walk + 9'd1;
        end else if (w_walk != '0) begin
            w_walk = w_walk - 9'd1;
        end
        // nudge back toward the normal band
        if (w_walk <= ffcg_pkg::FB_LOW) begin
            w_walk = w_walk + 9'd1;
        end else if (w_walk >= ffcg_pkg::FB_HIGH) begin
            w_walk = w_walk - 9'd1;
        end
        n_fb        = w_walk[ffcg_pkg::FB_W-1:0];
        n_red_idx   = move_idx(r_red_idx, i_draws.draw_red, w_top);
        n_green_idx = move_idx(r_green_idx, i_draws.draw_green, w_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb        <= ffcg_pkg::FB_RESET;
            r_red_idx   <= '0;
            r_green_idx <= '0;
        end else if (i_step) begin
            r_fb        <= n_fb;
            r_red_idx   <= n_red_idx;
            r_green_idx <= n_green_idx;
        end
    end

    assign o_fb        = r_fb;
    assign o_red_idx   = r_red_idx;
    assign o_green_idx = r_green_idx;

    `FFCG_ASSERT_NOW(a_fb_band, 1'b1, (r_fb >= 8'd130) && (r_fb <= 8'd200))
    `FFCG_ASSERT_NEXT(a_red_clamped, i_step, r_red_idx <= $past(w_top))
    `FFCG_ASSERT_NEXT(a_green_clamped, i_step, r_green_idx <= $past(w_top))

endmodule

`default_nettype wire

FILE: rtl/flame_flicker_color_generator_unit.sv
// top level of the flame flicker color generator: config registers,
// sequencer around one shared multiplier, output register
// depends on ffcg_pkg, ffcg_mul, ffcg_update and the assertion macro header
//
//  channel  direction  handshake               payload
//  in       to block   i_in_valid / o_in_stall  i_in_data  (t_in_req)
//  out      from block o_out_valid / i_out_stall o_out_data (t_out_res)
//  cfg      to block   i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// after acceptance a request steps through S_FB to S_FIN, then S_OUT loads the output register;
// the sequence is set by the seven products that share the single multiplier
// the block accepts no new request until the sequencer returns to S_IDLE, o_in_stall high meanwhile,
// a result waiting under i_out_stall holds the sequencer in its last step
// synchronous active-low reset: brightness 130, indices 0, scale 90, count 60
`default_nettype none
`include "flame_flicker_color_generator_unit_defines.svh"

module flame_flicker_color_generator_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire ffcg_pkg::t_in_req                  i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output ffcg_pkg::t_out_res                      o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [ffcg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ffcg_pkg::CFG_W-1:0]         i_cfg_wdata
);

    // sequencer steps; each step captures the product of the step before
    typedef enum logic [3:0] {
        S_IDLE,   // wait for a request, update state on accept
        S_FB,     // issue fb * scale
        S_QR,     // keep fb*scale, issue red_idx / 30 by reciprocal
        S_QG,     // red remainder, issue green_idx / 30
        S_PR,     // green remainder, issue m * template[red]
        S_PG,     // red partial >> 11, issue m * template[green]
        S_YR,     // green partial >> 13, issue red / 25
        S_YG,     // red level, issue green / 25
        S_FIN,    // green level
        S_OUT     // load output register once it is free
    } t_state;

    t_state r_state;

    logic [ffcg_pkg::SCALE_W-1:0] r_scale;
    logic [ffcg_pkg::CNT_W-1:0]   r_count;

    logic [ffcg_pkg::FB_W-1:0]    w_fb;
    logic [ffcg_pkg::IDX_W-1:0]   w_red_idx;
    logic [ffcg_pkg::IDX_W-1:0]   w_green_idx;
    logic                         w_accept;

    logic [ffcg_pkg::MUL_A_W-1:0] w_mul_a;
    logic [ffcg_pkg::MUL_B_W-1:0] w_mul_b;
    logic [ffcg_pkg::MUL_P_W-1:0] w_prod;

    logic [16:0]                  r_m;        // fb * scale
    logic [4:0]                   r_rem_r;
    logic [4:0]                   r_rem_g;
    logic [11:0]                  r_yr;       // red product >> 11
    logic [9:0]                   r_yg;       // green product >> 13
    logic [ffcg_pkg::LEVEL_W-1:0] r_red;
    logic [ffcg_pkg::LEVEL_W-1:0] r_grn;
    logic                         r_out_valid;
    ffcg_pkg::t_out_res           r_out;

    logic [ffcg_pkg::IDX_W-1:0]   w_rem_src;
    logic [5:0]                   w_quot;
    logic [ffcg_pkg::IDX_W:0]     w_quot30;
    logic [ffcg_pkg::IDX_W:0]     w_rem_full;
    logic                         w_out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // config writes, ignored for indexes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= ffcg_pkg::SCALE_RESET;
            r_count <= ffcg_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffcg_pkg::REG_BRIGHTNESS_SCALE: r_scale <= i_cfg_wdata[ffcg_pkg::SCALE_W-1:0];
                ffcg_pkg::REG_PIXEL_COUNT:      r_count <= i_cfg_wdata[ffcg_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    ffcg_update u_update (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_accept),
        .i_draws       (i_in_data),
        .i_pixel_count (r_count),
        .o_fb          (w_fb),
        .o_red_idx     (w_red_idx),
        .o_green_idx   (w_green_idx)
    );

    // remainder mod 30 from the quotient now in the product register
    always_comb begin
        w_rem_src  = (r_state == S_QG) ? w_red_idx : w_green_idx;
        w_quot     = w_prod[21:16];
        w_quot30   = {w_quot, 5'b0} - {4'b0, w_quot, 1'b0};
        w_rem_full = {1'b0, w_rem_src} - w_quot30;
    end

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_FB: begin
                w_mul_a = ffcg_pkg::MUL_A_W'(r_scale);
                w_mul_b = ffcg_pkg::MUL_B_W'(w_fb);
            end
            S_QR: begin
                w_mul_a = ffcg_pkg::MUL_A_W'(w_red_idx);
                w_mul_b = ffcg_pkg::RECIP_30;
            end
            S_QG: begin
                w_mul_a = ffcg_pkg::MUL_A_W'(w_green_idx);
                w_mul_b = ffcg_pkg::RECIP_30;
            end
            S_PR: begin
                w_mul_a = r_m;
                w_mul_b = ffcg_pkg::MUL_B_W'(ffcg_pkg::tpl_lookup(r_rem_r));
            end
            S_PG: begin
                w_mul_a = r_m;
                w_mul_b = ffcg_pkg::MUL_B_W'(ffcg_pkg::tpl_lookup(r_rem_g));
            end
            S_YR: begin
                w_mul_a = ffcg_pkg::MUL_A_W'(r_yr);
                w_mul_b = ffcg_pkg::RECIP_25;
            end
            S_YG: begin
                w_mul_a = ffcg_pkg::MUL_A_W'(r_yg);
                w_mul_b = ffcg_pkg::RECIP_25;
            end
            default: ;
        endcase
    end

    ffcg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a load in the output step replaces the taken result
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_FB;
                    end
                end
                S_FB: r_state <= S_QR;
                S_QR: begin
                    r_m     <= w_prod[16:0];
                    r_state <= S_QG;
                end
                S_QG: begin
                    r_rem_r <= w_rem_full[4:0];
                    r_state <= S_PR;
                end
                S_PR: begin
                    r_rem_g <= w_rem_full[4:0];
                    r_state <= S_PG;
                end
                S_PG: begin
                    // /51200 = >>11 then /25
                    r_yr    <= w_prod[22:11];
                    r_state <= S_YR;
                end
                S_YR: begin
                    // /204800 = >>13 then /25
                    r_yg    <= w_prod[22:13];
                    r_state <= S_YG;
                end
                S_YG: begin
                    r_red   <= w_prod[24:17];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_grn   <= w_prod[24:17];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.red_level   <= r_red;
                        r_out.green_level <= r_grn;
                        // fb * scale stays below 512000, so blue floors to zero
                        r_out.blue_level  <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `FFCG_ASSERT_NEXT(a_accept_starts, w_accept, r_state == S_FB)
    `FFCG_ASSERT_NOW(a_out_from_seq, $rose(r_out_valid), $past(r_state) == S_OUT)
    `FFCG_ASSERT_NOW(a_no_accept_busy, r_state != S_IDLE, !w_accept)

endmodule

`default_nettype wire
